### src/cat_text_stream_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text stream filter
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CAT_TEXT_STREAM_FILTER_UNIT_MACROS_SVH
`define CAT_TEXT_STREAM_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define CTSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctsf check failed");

// next-cycle implication
`define CTSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctsf check failed");

`else

`define CTSF_ASSERT_SAME(lbl, ante, cons)
`define CTSF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/ctsf_pkg.sv
// ----------------------------------------------------------------------------
// ctsf_pkg
// Shared types and character codes of the text stream filter.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CARET_OFS = 8'h40;

  localparam logic [1:0] NL_RUN_SAT   = 2'd3;
  localparam logic [1:0] NL_RUN_RESET = 2'd1;

  localparam logic [3:0] BCD_NINE = 4'd9;

  typedef enum logic [2:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

endpackage

### src/ctsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ctsf_cfg_regs
// APB register bank holding the six option bits.
// ----------------------------------------------------------------------------
module ctsf_cfg_regs
  import ctsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_t idx;
  logic     wr_en;
  logic     rd_bit;

  assign idx    = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    rd_bit  = 1'b0;
    case (idx)
      REG_NUMBER_NONBLANK: begin
        rd_bit = cfg_r.number_nonblank;
        if (wr_en) cfg_nxt.number_nonblank = pwdata[0];
      end
      REG_NUMBER_ALL: begin
        rd_bit = cfg_r.number_all;
        if (wr_en) cfg_nxt.number_all = pwdata[0];
      end
      REG_SQUEEZE_BLANK: begin
        rd_bit = cfg_r.squeeze_blank;
        if (wr_en) cfg_nxt.squeeze_blank = pwdata[0];
      end
      REG_SHOW_ENDS: begin
        rd_bit = cfg_r.show_ends;
        if (wr_en) cfg_nxt.show_ends = pwdata[0];
      end
      REG_SHOW_TABS: begin
        rd_bit = cfg_r.show_tabs;
        if (wr_en) cfg_nxt.show_tabs = pwdata[0];
      end
      REG_SHOW_NONPRINTING: begin
        rd_bit = cfg_r.show_nonprinting;
        if (wr_en) cfg_nxt.show_nonprinting = pwdata[0];
      end
      default: begin
        rd_bit = 1'b0;
      end
    endcase
  end

  assign prdata = {{(APB_DATA_W-1){1'b0}}, rd_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/ctsf_format.sv
// ----------------------------------------------------------------------------
// ctsf_format
// Line state and run builder: turns one byte into its output run.
// ----------------------------------------------------------------------------
module ctsf_format
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cfg_t                                        cfg,
  input  logic [7:0]                                  in_byte,
  input  logic                                        in_new_file,
  input  logic                                        commit,
  output logic                                        drop,
  output logic [NUMBER_DIGITS+2:0][7:0]               run_bytes,
  output logic [$clog2(NUMBER_DIGITS+4)-1:0]          run_len
);

  localparam int RUN_MAX = NUMBER_DIGITS + 3;
  localparam int CW      = $clog2(RUN_MAX + 1);

  // line number kept in BCD, digit 0 least significant
  logic [NUMBER_DIGITS-1:0][3:0] ln_r, ln_nxt, ln_base, ln_inc;
  logic [1:0]                    nlr_r, nlr_nxt, nlr_base;
  logic                          als_r, als_nxt, als_base;

  logic       is_nl, num_en, tab_vis, np, caret;
  logic [7:0] ch1, ch_fin;
  logic       all_nine, carry;
  logic [NUMBER_DIGITS-1:0] zero_lead;
  logic [CW-1:0] off1, off2, off3;

  assign is_nl = (in_byte == CH_NL);

  // state as seen by this byte, after a new-file restart
  assign nlr_base = in_new_file ? NL_RUN_RESET : nlr_r;
  assign als_base = in_new_file ? 1'b1 : als_r;
  always_comb begin
    ln_base = ln_r;
    if (in_new_file) begin
      ln_base    = '0;
      ln_base[0] = 4'd1;
    end
  end

  // squeeze tracking
  always_comb begin
    nlr_nxt = nlr_base;
    if (cfg.squeeze_blank) begin
      if (is_nl) begin
        nlr_nxt = (nlr_base == NL_RUN_SAT) ? NL_RUN_SAT : nlr_base + 2'd1;
      end else begin
        nlr_nxt = 2'd0;
      end
    end
  end
  assign drop = cfg.squeeze_blank && is_nl && (nlr_nxt == NL_RUN_SAT);

  // numbering; non-empty mode wins
  always_comb begin
    num_en  = 1'b0;
    als_nxt = als_base;
    if (cfg.number_nonblank) begin
      num_en  = als_base && !is_nl;
      als_nxt = is_nl ? 1'b1 : (num_en ? 1'b0 : als_base);
    end else if (cfg.number_all) begin
      num_en  = als_base;
      als_nxt = is_nl ? 1'b1 : (num_en ? 1'b0 : als_base);
    end
  end

  // saturating BCD increment
  always_comb begin
    all_nine = 1'b1;
    carry    = 1'b1;
    ln_inc   = ln_base;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (ln_base[i] != BCD_NINE) all_nine = 1'b0;
      if (carry) begin
        if (ln_base[i] == BCD_NINE) begin
          ln_inc[i] = 4'd0;
        end else begin
          ln_inc[i] = ln_base[i] + 4'd1;
          carry     = 1'b0;
        end
      end
    end
    if (all_nine) ln_inc = ln_base;
  end

  assign ln_nxt = num_en ? ln_inc : ln_base;

  // character escapes
  assign tab_vis = cfg.show_tabs && (in_byte == CH_TAB);
  assign ch1     = tab_vis ? CH_I : in_byte;
  assign np      = cfg.show_nonprinting && !((ch1 >= CH_SPACE) && (ch1 <= CH_TILDE))
                   && (ch1 != CH_NL) && (ch1 != CH_TAB);
  assign ch_fin  = np ? ((ch1 == CH_DEL) ? CH_QMARK : ch1 + CARET_OFS) : ch1;
  assign caret   = tab_vis || np;

  // leading zero blanking, display position 0 is the most significant digit
  always_comb begin
    logic run_zero;
    run_zero  = 1'b1;
    zero_lead = '0;
    for (int j = 0; j < NUMBER_DIGITS - 1; j++) begin
      run_zero     = run_zero && (ln_base[NUMBER_DIGITS-1-j] == 4'd0);
      zero_lead[j] = run_zero;
    end
  end

  assign off1 = num_en ? CW'(NUMBER_DIGITS + 1) : '0;
  assign off2 = off1 + CW'(cfg.show_ends && is_nl);
  assign off3 = off2 + CW'(caret);
  assign run_len = off3 + CW'(1);

  always_comb begin
    for (int j = 0; j < RUN_MAX; j++) begin
      run_bytes[j] = CH_SPACE;
      if (num_en && (j < NUMBER_DIGITS)) begin
        run_bytes[j] = zero_lead[j] ? CH_SPACE
                                    : CH_ZERO + {4'd0, ln_base[NUMBER_DIGITS-1-j]};
      end
      if (num_en && (j == NUMBER_DIGITS)) run_bytes[j] = CH_TAB;
      if (cfg.show_ends && is_nl && (CW'(j) == off1)) run_bytes[j] = CH_DOLLAR;
      if (caret && (CW'(j) == off2)) run_bytes[j] = CH_CARET;
      if (CW'(j) == off3) run_bytes[j] = ch_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlr_r    <= NL_RUN_RESET;
      als_r    <= 1'b1;
      ln_r     <= {{(4*NUMBER_DIGITS-1){1'b0}}, 1'b1};
    end else if (commit) begin
      nlr_r <= nlr_nxt;
      als_r <= drop ? als_base : als_nxt;
      ln_r  <= drop ? ln_base : ln_nxt;
    end
  end

endmodule

### src/ctsf_run_buf.sv
// ----------------------------------------------------------------------------
// ctsf_run_buf
// Output run register, shifts one beat out per accepted output.
// ----------------------------------------------------------------------------
module ctsf_run_buf
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [NUMBER_DIGITS+2:0][7:0]        load_bytes,
  input  logic [$clog2(NUMBER_DIGITS+4)-1:0]   load_len,
  output logic                                 can_load,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_last_of_run
);

  localparam int RUN_MAX = NUMBER_DIGITS + 3;
  localparam int CW      = $clog2(RUN_MAX + 1);

  logic [RUN_MAX-1:0][7:0] buf_r;
  logic [CW-1:0]           cnt_r;
  logic                    take;

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = buf_r[0];
  assign out_last_of_run = (cnt_r == CW'(1));
  assign take            = out_valid && !out_stall;
  assign can_load        = !out_valid || (out_last_of_run && take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_len;
    end else if (take) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_bytes;
    end else if (take) begin
      for (int j = 0; j < RUN_MAX - 1; j++) begin
        buf_r[j] <= buf_r[j+1];
      end
    end
  end

endmodule

### src/cat_text_stream_filter_unit.sv
// ----------------------------------------------------------------------------
// cat_text_stream_filter_unit: input beats pass the input register, then the run buffer.
// Throughput one input beat per cycle while each byte gives one output beat and the
// output does not stall; a longer run holds the input until the shift register drains.
// Sync active-low reset: options off, line number 1, at line start, newline run 1.
// ----------------------------------------------------------------------------

`include "cat_text_stream_filter_unit_macros.svh"

// Data path:
//   input register -> ctsf_format (combinational run build + line state)
//   -> ctsf_run_buf (up to NUMBER_DIGITS+3 bytes, one beat per cycle out unless stalled).
// A squeezed newline is retired from the input register without output.
// The input register refills in the same cycle the run buffer takes its run,
// so the two sides never wait on each other beyond the length of a run.
module cat_text_stream_filter_unit
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_new_file,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last_of_run,
  // APB config
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int RUN_MAX = NUMBER_DIGITS + 3;
  localparam int CW      = $clog2(RUN_MAX + 1);

  cfg_t cfg;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_nf_r;

  logic                    drop;
  logic                    can_load;
  logic                    adv;
  logic                    run_load;
  logic                    in_take;
  logic [RUN_MAX-1:0][7:0] run_bytes;
  logic [CW-1:0]           run_len;

  ctsf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // held byte leaves when it is squeezed or the run buffer frees up
  assign adv      = in_vld_r && (drop || can_load);
  assign run_load = in_vld_r && !drop && can_load;
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_nf_r   <= in_new_file;
    end
  end

  ctsf_format #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_format (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_byte     (in_byte_r),
    .in_new_file (in_nf_r),
    .commit      (adv),
    .drop        (drop),
    .run_bytes   (run_bytes),
    .run_len     (run_len)
  );

  ctsf_run_buf #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_run_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (run_load),
    .load_bytes      (run_bytes),
    .load_len        (run_len),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // a loaded run is never empty and fits the buffer
  `CTSF_ASSERT_SAME(a_run_len_range, run_load, (run_len != '0) && (run_len <= CW'(RUN_MAX)))
  // only a newline under squeeze mode is ever dropped
  `CTSF_ASSERT_SAME(a_drop_is_nl, in_vld_r && drop, cfg.squeeze_blank && (in_byte_r == CH_NL))
  // a run continues after a beat that is not its last
  `CTSF_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last_of_run, out_valid)

endmodule

### tb/cat_text_stream_filter_unit_checker.sv
// ----------------------------------------------------------------------------
// cat_text_stream_filter_unit_checker
// Watches the config port and both beat channels. It keeps its own copy of the
// options and line state, builds the expected output run of each input byte,
// and compares every output beat against the oldest expected one.
// ----------------------------------------------------------------------------
module cat_text_stream_filter_unit_checker
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_new_file,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_byte,
  input  logic                  out_last_of_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    beats_out,
  output int                    squeezed
);

  localparam longint LINE_MAX = longint'(10) ** NUMBER_DIGITS - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } fmt_beat_t;

  fmt_beat_t  expected_q[$];
  cfg_t       opts;
  logic [1:0] nl_run;
  longint     line_no;
  logic       at_start;

  initial begin
    fail_count = 0;
    pending    = 0;
    beats_out  = 0;
    squeezed   = 0;
  end

  task automatic report_mismatch(input string what, input string detail);
    $display("%0t: MISMATCH beat %0d %s: %s", $time, beats_out, what, detail);
    fail_count++;
  endtask

  task automatic push_beat(input logic [7:0] b);
    expected_q.push_back('{data: b, last: 1'b0});
  endtask

  // right-aligned, space-padded line number followed by a tab
  task automatic push_line_number();
    longint     v;
    logic [7:0] digit[NUMBER_DIGITS];
    int         i;
    v = (line_no > LINE_MAX) ? LINE_MAX : line_no;
    for (i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      digit[i] = CH_ZERO + 8'(v % 10);
      v = v / 10;
    end
    for (i = 0; i < NUMBER_DIGITS - 1 && digit[i] == CH_ZERO; i++)
      digit[i] = CH_SPACE;
    for (i = 0; i < NUMBER_DIGITS; i++)
      push_beat(digit[i]);
    push_beat(CH_TAB);
    if (line_no < LINE_MAX) line_no++;
    else line_no = LINE_MAX;
  endtask

  task automatic format_byte(input logic [7:0] b, input logic nf);
    logic [7:0] ch;
    logic       is_nl;
    ch    = b;
    is_nl = (b == CH_NL);
    if (nf) begin
      nl_run   = NL_RUN_RESET;
      line_no  = 1;
      at_start = 1'b1;
    end
    if (opts.squeeze_blank) begin
      if (is_nl) begin
        if (nl_run < NL_RUN_SAT) nl_run++;
        if (nl_run >= NL_RUN_SAT) begin
          squeezed++;
          return;
        end
      end else begin
        nl_run = '0;
      end
    end
    // non-empty numbering wins when both modes are set
    if (opts.number_nonblank) begin
      if (at_start && !is_nl) begin
        push_line_number();
        at_start = 1'b0;
      end
      if (is_nl) at_start = 1'b1;
    end else if (opts.number_all) begin
      if (at_start) begin
        push_line_number();
        at_start = 1'b0;
      end
      if (is_nl) at_start = 1'b1;
    end
    if (opts.show_ends && is_nl) push_beat(CH_DOLLAR);
    if (opts.show_tabs && ch == CH_TAB) begin
      push_beat(CH_CARET);
      ch = CH_I;
    end
    if (opts.show_nonprinting && (ch < CH_SPACE || ch > CH_TILDE) &&
        ch != CH_NL && ch != CH_TAB) begin
      push_beat(CH_CARET);
      ch = (ch == CH_DEL) ? CH_QMARK : ch + CARET_OFS;
    end
    expected_q.push_back('{data: ch, last: 1'b1});
  endtask

  always @(posedge clk) begin : monitor
    fmt_beat_t want;
    if (!rst_n) begin
      opts     = '0;
      nl_run   = NL_RUN_RESET;
      line_no  = 1;
      at_start = 1'b1;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[APB_ADDR_W-1:2]))
          REG_NUMBER_NONBLANK: begin
            opts.number_nonblank = pwdata[0];
          end
          REG_NUMBER_ALL: begin
            opts.number_all = pwdata[0];
          end
          REG_SQUEEZE_BLANK: begin
            opts.squeeze_blank = pwdata[0];
          end
          REG_SHOW_ENDS: begin
            opts.show_ends = pwdata[0];
          end
          REG_SHOW_TABS: begin
            opts.show_tabs = pwdata[0];
          end
          REG_SHOW_NONPRINTING: begin
            opts.show_nonprinting = pwdata[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) format_byte(in_byte, in_new_file);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat",
                          $sformatf("byte %h last %b", out_byte, out_last_of_run));
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", $sformatf("got %h, want %h", out_byte, want.data));
          if (out_last_of_run !== want.last)
            report_mismatch("out_last_of_run",
                            $sformatf("got %b, want %b", out_last_of_run, want.last));
        end
        beats_out++;
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/cat_text_stream_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// cat_text_stream_filter_unit_tb
// Drives text bytes through the filter under a series of option settings:
// a short directed opening, then line-shaped random text with blank runs,
// file starts and raw noise. A checker beside the block predicts each run.
// ----------------------------------------------------------------------------
module cat_text_stream_filter_unit_tb;
  import ctsf_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 7;
  localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES   = 8;     // covers a squeezed newline still in flight
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int BYTES_PER_PHASE = 46;

  // block inputs, all known from time zero
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic [7:0]            in_byte     = '0;
  logic                  in_new_file = 1'b0;
  logic                  out_stall   = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            out_byte;
  logic                  out_last_of_run;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int beats_out;
  int squeezed;

  int bytes_sent    = 0;
  int settings_run  = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  bit traffic_gaps  = 1'b1;  // cleared for the final phase

  cat_text_stream_filter_unit #(
    .NUMBER_DIGITS(NUMBER_DIGITS_DEF)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_new_file    (in_new_file),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  cat_text_stream_filter_unit_checker #(
    .NUMBER_DIGITS(NUMBER_DIGITS_DEF)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_new_file    (in_new_file),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .beats_out      (beats_out),
    .squeezed       (squeezed)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Output back-pressure: stall bursts of random length with quiet stretches
  // between them. Bursts land on any beat of a run, numbers and escapes too.
  always @(negedge clk) begin
    if (!traffic_gaps) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a hung handshake shows up as a long stretch with no beat at all.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT after %0d idle cycles, %0d beats still expected",
               idle_cycles, pending);
      $display("cat_text_stream_filter_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input cfg_reg_t r, input logic v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {{(APB_DATA_W-1){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_options(input cfg_t o);
    cfg_write(REG_NUMBER_NONBLANK,  o.number_nonblank);
    cfg_write(REG_NUMBER_ALL,       o.number_all);
    cfg_write(REG_SQUEEZE_BLANK,    o.squeeze_blank);
    cfg_write(REG_SHOW_ENDS,        o.show_ends);
    cfg_write(REG_SHOW_TABS,        o.show_tabs);
    cfg_write(REG_SHOW_NONPRINTING, o.show_nonprinting);
    settings_run++;
  endtask

  // Options only change with the block idle: all expected beats out, the input
  // side quiet, plus a settling wait for a squeezed newline that makes no beat.
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Entered at a falling edge, returns at the falling edge after the beat.
  // Valid stays up across back-to-back beats; a random gap may drop it before a beat.
  task automatic send_byte(input logic [7:0] b, input logic nf);
    if (traffic_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_new_file <= nf;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Plain text for under half the bytes, with a heavy share of tabs, control, DEL and high bytes.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(32, 126));
    else if (r < 55) return CH_TAB;
    else if (r < 68) return 8'($urandom_range(0, 31));
    else if (r < 75) return CH_DEL;
    else if (r < 95) return 8'($urandom_range(128, 255));
    else return 8'($urandom_range(0, 255));
  endfunction

  // Random text: whole lines (some opening a new file), runs of blank lines
  // to drive the squeeze logic, and short bursts of raw noise.
  task automatic send_text(input int count);
    int   target;
    int   len;
    int   kind;
    logic nf;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        nf  = ($urandom_range(0, 11) == 0);
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
          send_byte(pick_text_byte(), nf);
          nf = 1'b0;
        end
        send_byte(CH_NL, nf);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 4)) send_byte(CH_NL, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic send_list(input logic [8:0] items[$]);
    foreach (items[k]) send_byte(items[k][7:0], items[k][8]);
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [8:0] all_on_list[$];
    logic [8:0] number_all_list[$];
    cfg_t       phase_opts[RANDOM_PHASES];

    // {new_file, byte}. With every option on: numbering of a non-empty line,
    // caret forms at the control, DEL and high-byte edges, a visible tab, end
    // markers, a blank run long enough to squeeze, and file restarts.
    all_on_list = '{
      {1'b1, 8'h41}, {1'b0, 8'h00}, {1'b0, 8'h1F}, {1'b0, CH_SPACE},
      {1'b0, CH_TILDE}, {1'b0, CH_DEL}, {1'b0, 8'h80}, {1'b0, 8'hFF},
      {1'b0, CH_TAB}, {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_NL},
      {1'b0, CH_NL}, {1'b0, 8'h78}, {1'b0, CH_NL}, {1'b1, 8'hFF},
      {1'b1, CH_NL}
    };
    // all-line numbering alone, tab shown without caret mode, raw bytes
    number_all_list = '{
      {1'b1, CH_NL}, {1'b0, CH_TAB}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_NL}
    };

    // settings per random phase; bit order follows cfg_t:
    // nonblank, all, squeeze, ends, tabs, nonprinting
    phase_opts[0] = '0;
    phase_opts[1] = '1;
    phase_opts[2] = cfg_t'(6'b011100);
    phase_opts[3] = cfg_t'(6'b100011);
    for (int p = 4; p < RANDOM_PHASES; p++)
      phase_opts[p] = cfg_t'(6'($urandom_range(0, 63)));

    // single reset at the start of the run
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    apply_options('1);
    send_list(all_on_list);
    wait_drained();
    apply_options(cfg_t'(6'b010010));
    send_list(number_all_list);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // the final phase runs at full rate on both sides
      if (p == RANDOM_PHASES - 1) traffic_gaps = 1'b0;
      apply_options(phase_opts[p]);
      send_text(BYTES_PER_PHASE);
      wait_drained();
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d input bytes under %0d option settings -> %0d output beats",
             bytes_sent, settings_run, beats_out);
    $display("summary: %0d newlines squeezed, %0d mismatches", squeezed, fail_count);
    if (fail_count == 0) begin
      $display("cat_text_stream_filter_unit verification clean");
    end else begin
      $display("cat_text_stream_filter_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/ctsf_pkg.sv
src/ctsf_cfg_regs.sv
src/ctsf_format.sv
src/ctsf_run_buf.sv
src/cat_text_stream_filter_unit.sv
tb/cat_text_stream_filter_unit_checker.sv
tb/cat_text_stream_filter_unit_tb.sv
